@@ src/slwm_pkg.sv @@
// Shared types and constants of the stage latency monitor.
package slwm_pkg;

  localparam int SLOT_W     = 3;
  localparam int HW_SLOTS   = 8;
  localparam int TS_W       = 63;
  localparam int CNT_W      = 16;
  localparam int MEAN_OUT_W = 36;
  localparam int VAR_W      = 56;
  localparam int DIV_W      = 64;
  localparam int DVSR_W     = 16;
  localparam int STEP_W     = 7;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // Divider launch: a one-cycle go and the number of quotient bits to form
  typedef struct packed {
    logic              go;
    logic [STEP_W-1:0] steps;
  } div_req_t;

endpackage

@@ src/stage_latency_welford_monitor.sv @@
// Top level of the per-stage latency monitor with running mean and variance.
//
//  channel  | ports                                         | handshake
//  ---------+-----------------------------------------------+------------------------
//  command  | cmd from_slot to_slot timestamp               | start high, busy low
//  result   | slot_index has_data sample_count mean_latency | strobe, one cycle each
//           | latency_variance last                         |
//  config   | cfg_data                                      | cfg_we, taken at once
//
// A transfer that records a sample passes through the serial divider, which forms
// the mean step, and the shift-add multiplier, which forms the M2 term, one bit
// a cycle each. A transfer with no pop ends after the push and read states; one
// whose start time is not earlier ends after the wait and latency states.
// A report scans every slot and runs the divider once for each enabled
// slot with samples. busy stays high from acceptance to the end.
// Reset (rst, synchronous) clears enables, FIFO pointers and statistics.
// Result beats cannot be stalled by the receiver.
module stage_latency_welford_monitor #(
  parameter int NUM_SLOTS    = 8,
  parameter int FIFO_DEPTH   = 8,
  parameter int LATENCY_BITS = 28
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cmd,
  input  logic [slwm_pkg::SLOT_W-1:0]       from_slot,
  input  logic [slwm_pkg::SLOT_W-1:0]       to_slot,
  input  logic [slwm_pkg::TS_W-1:0]         timestamp,
  input  logic                              cfg_we,
  input  logic [slwm_pkg::HW_SLOTS-1:0]     cfg_data,
  output logic                              strobe,
  output logic [slwm_pkg::SLOT_W-1:0]       slot_index,
  output logic                              has_data,
  output logic [slwm_pkg::CNT_W-1:0]        sample_count,
  output logic [slwm_pkg::MEAN_OUT_W-1:0]   mean_latency,
  output logic [slwm_pkg::VAR_W-1:0]        latency_variance,
  output logic                              last
);
  import slwm_pkg::*;

  localparam int NS   = (NUM_SLOTS < HW_SLOTS) ? NUM_SLOTS : HW_SLOTS;
  localparam int SW   = $clog2(NS);
  localparam int PW   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FW   = $clog2(FIFO_DEPTH + 1);
  localparam int MD   = NS * FIFO_DEPTH;
  localparam int AW   = (MD > 1) ? $clog2(MD) : 1;
  localparam int MW   = LATENCY_BITS + 8;
  localparam int PRW  = 2 * MW;
  localparam logic [FW-1:0] DEPTH_F = FW'(FIFO_DEPTH);
  localparam logic [LATENCY_BITS-1:0] LAT_MAX = '1;

  typedef enum logic [3:0] {
    S_IDLE, S_PUSH, S_READ, S_WAIT, S_LAT, S_DIVM, S_MUL0, S_MUL, S_ACC,
    S_SCAN, S_DIVV
  } state_t;

  state_t state;

  logic [HW_SLOTS-1:0] slot_enable;
  logic [PW-1:0]       head  [NS];
  logic [FW-1:0]       fill  [NS];
  logic [MW-1:0]       mean  [NS];
  logic [63:0]         m2    [NS];
  logic [CNT_W-1:0]    tally [NS];

  logic [TS_W-1:0] fifo_mem [MD];
  logic [TS_W-1:0] rd_data;

  logic [SLOT_W-1:0] from_r, to_r;
  logic [TS_W-1:0]   ts_r;
  logic [LATENCY_BITS-1:0] lat;
  logic [MW-1:0]     x_r, mag1;
  logic              up;
  logic [CNT_W-1:0]  n_r;
  logic [PRW-1:0]    prod;
  logic [STEP_W-1:0] mcnt;
  logic [SW:0]       scan;

  div_req_t          dreq;
  logic [DIV_W-1:0]  dvd;
  logic [DVSR_W-1:0] dvs;
  logic              ddone;
  logic [DIV_W-1:0]  dquo;

  logic [SW-1:0] fi, ti, si;
  logic          from_on, to_on;
  logic [FW:0]   pos_sum;
  logic [PW-1:0] pos;
  logic [PW-1:0] head_inc;
  logic [TS_W-1:0] lat_full;
  logic [MW-1:0] m_cur, m_new;
  logic [MW:0]   msum;
  logic [64:0]   m2_sum;
  logic [63:0]   mean64;
  logic [NS-1:0] en_hi;

  assign fi = from_r[SW-1:0];
  assign ti = to_r[SW-1:0];
  assign si = scan[SW-1:0];
  assign from_on = (32'(from_r) < NS) && slot_enable[from_r];
  assign to_on   = (32'(to_r) < NS) && slot_enable[to_r];
  assign busy    = (state != S_IDLE);

  // Write position in the receiving FIFO, wrapped once
  assign pos_sum = (FW+1)'(head[ti]) + (FW+1)'(fill[ti]);
  assign pos     = (pos_sum >= (FW+1)'(FIFO_DEPTH)) ? PW'(pos_sum - (FW+1)'(FIFO_DEPTH))
                                                    : PW'(pos_sum);
  assign head_inc = (32'(head[fi]) + 1 == FIFO_DEPTH) ? '0 : PW'(head[fi] + 1'b1);

  // Latency of the popped start time, saturated
  assign lat_full = ts_r - rd_data;
  assign lat = (lat_full >> LATENCY_BITS) != '0 ? LAT_MAX : lat_full[LATENCY_BITS-1:0];

  assign m_cur = mean[fi];
  assign msum  = up ? ({1'b0, m_cur} + {1'b0, dquo[MW-1:0]})
                    : ({1'b0, m_cur} - {1'b0, dquo[MW-1:0]});
  assign m_new = msum[MW-1:0];
  assign m2_sum = {1'b0, m2[fi]} + 65'(prod[PRW-1:16]);
  assign mean64 = 64'(mean[si]);
  assign en_hi  = slot_enable[NS-1:0] >> si;

  // Launch operands for the shared divider
  always_comb begin
    dreq = '0;
    dvd  = '0;
    dvs  = '0;
    if (state == S_LAT) begin
      dreq.go    = (ts_r > rd_data);
      dreq.steps = STEP_W'(MW);
      dvd        = {mag1, (DIV_W-MW)'(0)};
      dvs        = n_r;
    end else if (state == S_SCAN && 32'(scan) < NS && slot_enable[si] && tally[si] != '0) begin
      dreq.go    = 1'b1;
      dreq.steps = STEP_W'(DIV_W);
      dvd        = m2[si];
      dvs        = tally[si];
    end
  end

  slwm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (dreq),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (ddone),
    .quotient (dquo)
  );

  // Store start times; read the head entry into a register
  always_ff @(posedge clk) begin
    if (state == S_PUSH && to_on && fill[ti] < DEPTH_F)
      fifo_mem[AW'(32'(ti) * FIFO_DEPTH + 32'(pos))] <= ts_r;
    if (state == S_READ)
      rd_data <= fifo_mem[AW'(32'(fi) * FIFO_DEPTH + 32'(head[fi]))];
  end

  // Sequencer, slot state and result beat
  always_ff @(posedge clk) begin
    strobe <= 1'b0;
    if (rst) begin
      state       <= S_IDLE;
      slot_enable <= '0;
      scan        <= '0;
      for (int s = 0; s < NS; s++) begin
        head[s]  <= '0;
        fill[s]  <= '0;
        mean[s]  <= '0;
        m2[s]    <= '0;
        tally[s] <= '0;
      end
    end else begin
      // Drop the state of every slot being switched off
      if (cfg_we) begin
        slot_enable <= cfg_data;
        for (int s = 0; s < NS; s++) begin
          if (slot_enable[s] && !cfg_data[s]) begin
            head[s]  <= '0;
            fill[s]  <= '0;
            mean[s]  <= '0;
            m2[s]    <= '0;
            tally[s] <= '0;
          end
        end
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            from_r <= from_slot;
            to_r   <= to_slot;
            ts_r   <= timestamp;
            scan   <= '0;
            state  <= cmd ? S_SCAN : S_PUSH;
          end
        end
        S_PUSH: begin
          if (to_on && fill[ti] < DEPTH_F)
            fill[ti] <= fill[ti] + 1'b1;
          state <= S_READ;
        end
        S_READ: begin
          if (from_on && fill[fi] != '0) begin
            head[fi] <= head_inc;
            fill[fi] <= fill[fi] - 1'b1;
            state    <= S_WAIT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_WAIT: begin
          x_r   <= {lat, 8'h00};
          up    <= ({lat, 8'h00} >= m_cur);
          mag1  <= ({lat, 8'h00} >= m_cur) ? ({lat, 8'h00} - m_cur) : (m_cur - {lat, 8'h00});
          n_r   <= (tally[fi] < COUNT_MAX) ? tally[fi] + 1'b1 : COUNT_MAX;
          state <= S_LAT;
        end
        S_LAT: begin
          state <= (ts_r > rd_data) ? S_DIVM : S_IDLE;
        end
        S_DIVM: begin
          if (ddone) begin
            mean[fi]  <= m_new;
            tally[fi] <= n_r;
            state     <= S_MUL0;
          end
        end
        S_MUL0: begin
          prod  <= {MW'(0), (up ? (x_r - m_cur) : (m_cur - x_r))};
          mcnt  <= STEP_W'(MW);
          state <= S_MUL;
        end
        S_MUL: begin
          prod <= {({1'b0, prod[PRW-1:MW]} + (prod[0] ? {1'b0, mag1} : '0)),
                   prod[MW-1:1]};
          mcnt <= mcnt - 1'b1;
          if (mcnt == STEP_W'(1))
            state <= S_ACC;
        end
        S_ACC: begin
          m2[fi] <= m2_sum[64] ? '1 : m2_sum[63:0];
          state  <= S_IDLE;
        end
        S_SCAN: begin
          if (32'(scan) >= NS) begin
            for (int s = 0; s < NS; s++) begin
              mean[s]  <= '0;
              m2[s]    <= '0;
              tally[s] <= '0;
            end
            state <= S_IDLE;
          end else if (slot_enable[si]) begin
            slot_index <= SLOT_W'(scan);
            last       <= (en_hi[NS-1:1] == '0);
            if (tally[si] == '0) begin
              strobe           <= 1'b1;
              has_data         <= 1'b0;
              sample_count     <= '0;
              mean_latency     <= '0;
              latency_variance <= '0;
              scan             <= scan + 1'b1;
            end else begin
              state <= S_DIVV;
            end
          end else begin
            scan <= scan + 1'b1;
          end
        end
        S_DIVV: begin
          if (ddone) begin
            strobe           <= 1'b1;
            has_data         <= 1'b1;
            sample_count     <= tally[si];
            mean_latency     <= mean64[MEAN_OUT_W-1:0];
            latency_variance <= (dquo[DIV_W-1:VAR_W] != '0) ? '1 : dquo[VAR_W-1:0];
            scan             <= scan + 1'b1;
            state            <= S_SCAN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/slwm_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by mean and variance.
module slwm_div (
  input  logic                      clk,
  input  logic                      rst,
  input  slwm_pkg::div_req_t        req,
  input  logic [slwm_pkg::DIV_W-1:0]  dividend,
  input  logic [slwm_pkg::DVSR_W-1:0] divisor,
  output logic                      done,
  output logic [slwm_pkg::DIV_W-1:0]  quotient
);
  import slwm_pkg::*;

  logic [DVSR_W-1:0] rem;
  logic [DVSR_W-1:0] dvsr;
  logic [DIV_W-1:0]  quo;
  logic [STEP_W-1:0] cnt;
  logic              run;
  logic [DVSR_W+1:0] diff;
  logic              ge;

  // Trial subtract of the divisor from the shifted partial remainder
  assign diff = {1'b0, rem, quo[DIV_W-1]} - {2'b00, dvsr};
  assign ge   = !diff[DVSR_W+1];
  assign quotient = quo;

  // Hold operands, advance one bit a cycle, pulse done on the last bit
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (req.go) begin
      run  <= 1'b1;
      cnt  <= req.steps;
      rem  <= '0;
      quo  <= dividend;
      dvsr <= divisor;
    end else if (run) begin
      rem <= ge ? diff[DVSR_W-1:0] : {rem[DVSR_W-2:0], quo[DIV_W-1]};
      quo <= {quo[DIV_W-2:0], ge};
      cnt <= cnt - 1'b1;
      if (cnt == STEP_W'(1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

@@ dv/stage_latency_welford_monitor_test.sv @@
// Self-checking testbench of the per-stage latency monitor.
module stage_latency_welford_monitor_test;
  import slwm_pkg::*;

  localparam int NSLOT = 8;
  localparam int DEPTH = 8;
  localparam int LBITS = 28;
  localparam logic CMD_XFER   = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  typedef struct packed {
    logic [SLOT_W-1:0]     slot;
    logic                  has;
    logic [CNT_W-1:0]      cnt;
    logic [MEAN_OUT_W-1:0] mean;
    logic [VAR_W-1:0]      var_q;
    logic                  lst;
  } line_t;

  // Latency statistics predictor with the queue of expected report lines
  class latency_board;
    logic [7:0]  enables;
    logic [63:0] starts [NSLOT][DEPTH];
    int          head   [NSLOT];
    int          fill   [NSLOT];
    logic [63:0] mean_q [NSLOT];
    logic [63:0] m2     [NSLOT];
    int          tally  [NSLOT];
    line_t       pending[$];
    int          errors;

    function void wipe(int s);
      head[s] = 0; fill[s] = 0; mean_q[s] = 0; m2[s] = 0; tally[s] = 0;
    endfunction

    function void reset_all();
      enables = 0; errors = 0;
      for (int s = 0; s < NSLOT; s++) wipe(s);
    endfunction

    function void set_enables(logic [7:0] v);
      for (int s = 0; s < NSLOT; s++)
        if (enables[s] && !v[s]) wipe(s);
      enables = v;
    endfunction

    function void fold(int s, logic [63:0] lat);
      logic [63:0] x, m, d1, d2, q;
      logic [127:0] prod;
      logic [64:0] sum;
      int n;
      n = (tally[s] < 65535) ? tally[s] + 1 : 65535;
      tally[s] = n;
      x = lat << 8;
      m = mean_q[s];
      d1 = (x >= m) ? x - m : m - x;
      q = d1 / n;
      m = (x >= m) ? m + q : m - q;
      mean_q[s] = m;
      d2 = (x >= m) ? x - m : m - x;
      prod = (d1 * 128'd1) * d2;
      prod = prod >> 16;
      sum = {1'b0, m2[s]} + ((prod[127:64] != 0) ? {1'b0, 64'hFFFF_FFFF_FFFF_FFFF}
                                               : {1'b0, prod[63:0]});
      m2[s] = sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
    endfunction

    // Note one accepted command beat
    function void note_beat(logic c, int from_in, int to_in, logic [62:0] ts);
      logic [63:0] st, lat, v;
      line_t l;
      int from, to;
      from = from_in & 7;
      to   = to_in & 7;
      if (c == CMD_REPORT) begin
        for (int s = 0; s < NSLOT; s++) begin
          if (!enables[s]) continue;
          l = '0;
          l.slot = SLOT_W'(s);
          if (tally[s] != 0) begin
            l.has = 1; l.cnt = CNT_W'(tally[s]); l.mean = mean_q[s][35:0];
            v = m2[s] / tally[s];
            l.var_q = (v > 64'hFF_FFFF_FFFF_FFFF) ? '1 : v[55:0];
          end
          pending.push_back(l);
        end
        if (enables != 0) pending[$].lst = 1;
        for (int s = 0; s < NSLOT; s++) begin
          mean_q[s] = 0; m2[s] = 0; tally[s] = 0;
        end
        return;
      end
      if (enables[to] && fill[to] < DEPTH) begin
        starts[to][(head[to] + fill[to]) % DEPTH] = {1'b0, ts};
        fill[to]++;
      end
      if (enables[from] && fill[from] > 0) begin
        st = starts[from][head[from]];
        head[from] = (head[from] + 1) % DEPTH;
        fill[from]--;
        if ({1'b0, ts} > st) begin
          lat = {1'b0, ts} - st;
          if (lat > (64'd1 << LBITS) - 1) lat = (64'd1 << LBITS) - 1;
          fold(from, lat);
        end
      end
    endfunction

    // Check one result beat against the oldest expected line
    function void check_line(line_t got);
      line_t e;
      if (pending.size() == 0) begin
        $error("unexpected report line for slot %0d", got.slot);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.slot !== e.slot) begin
        $error("slot_index exp %0d got %0d", e.slot, got.slot); errors++;
      end
      if (got.has !== e.has) begin
        $error("has_data exp %0d got %0d", e.has, got.has); errors++;
      end
      if (got.cnt !== e.cnt) begin
        $error("sample_count exp %0d got %0d", e.cnt, got.cnt); errors++;
      end
      if (got.mean !== e.mean) begin
        $error("mean_latency exp %0h got %0h", e.mean, got.mean); errors++;
      end
      if (got.var_q !== e.var_q) begin
        $error("latency_variance exp %0h got %0h", e.var_q, got.var_q); errors++;
      end
      if (got.lst !== e.lst) begin
        $error("last exp %0d got %0d", e.lst, got.lst); errors++;
      end
    endfunction
  endclass

  logic clk, rst, start, busy, cmd, cfg_we, strobe, has_data, last;
  logic [SLOT_W-1:0] from_slot, to_slot, slot_index;
  logic [TS_W-1:0] timestamp;
  logic [HW_SLOTS-1:0] cfg_data;
  logic [CNT_W-1:0] sample_count;
  logic [MEAN_OUT_W-1:0] mean_latency;
  logic [VAR_W-1:0] latency_variance;

  latency_board board;
  logic [62:0] now_ns;

  stage_latency_welford_monitor u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .from_slot(from_slot), .to_slot(to_slot), .timestamp(timestamp),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .strobe(strobe),
    .slot_index(slot_index), .has_data(has_data), .sample_count(sample_count),
    .mean_latency(mean_latency), .latency_variance(latency_variance), .last(last)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("stage_latency_welford_monitor regression: fail");
    $finish;
  end

  // Take result beats
  always @(posedge clk) begin
    if (!rst && strobe)
      board.check_line('{slot_index, has_data, sample_count, mean_latency,
                         latency_variance, last});
  end

  // Drive one command beat and hold it until taken
  task automatic send(logic c, int from, int to, logic [62:0] ts);
    start <= 1; cmd <= c; from_slot <= SLOT_W'(from); to_slot <= SLOT_W'(to);
    timestamp <= ts;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_beat(c, from, to, ts);
    start <= 0;
    @(posedge clk);
  endtask

  task automatic idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return;
    repeat ((r < 92) ? $urandom_range(1, 4) : $urandom_range(20, 120)) @(posedge clk);
  endtask

  // Drain expected lines and let the block settle
  task automatic drain();
    int guard;
    guard = 0;
    while ((board.pending.size() != 0 || busy) && guard < 20000) begin
      @(posedge clk); guard++;
    end
    repeat (200) @(posedge clk);
  endtask

  task automatic set_cfg(logic [7:0] v);
    drain();
    cfg_we <= 1; cfg_data <= v;
    @(posedge clk);
    board.set_enables(v);
    cfg_we <= 0;
  endtask

  // Advance time and transfer between stages
  task automatic xfer(int from, int to, int step_max);
    now_ns = now_ns + $urandom_range(0, step_max);
    send(CMD_XFER, from, to, now_ns);
  endtask

  initial begin
    logic [62:0] ts;
    logic [7:0] masks[5];
    board = new();
    board.reset_all();
    rst = 1; start = 0; cmd = 0; from_slot = 0; to_slot = 0; timestamp = 0;
    cfg_we = 0; cfg_data = 0;
    now_ns = 1000;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: nothing enabled, then extremes, saturation and special cases
    send(CMD_REPORT, 7, 7, '1);
    set_cfg(8'hFF);
    send(CMD_XFER, 0, 1, 63'd100);
    send(CMD_XFER, 1, 2, 63'd100);                     // start not earlier
    send(CMD_XFER, 3, 3, 63'd50);                      // same slot, no latency
    send(CMD_XFER, 7, 4, 63'd0);                       // pop from empty FIFO
    send(CMD_XFER, 4, 5, 63'h7FFF_FFFF_FFFF_FFFF);     // saturated latency
    send(CMD_XFER, 5, 6, 63'h7FFF_FFFF_FFFF_FFFF);
    for (int i = 0; i < 10; i++) send(CMD_XFER, 0, 6, 63'd200 + i); // full FIFO
    send(CMD_XFER, 6, 0, 63'd5000);
    send(CMD_REPORT, 0, 0, 63'h5555_5555_5555_5555);
    set_cfg(8'h00);
    send(CMD_XFER, 2, 2, 63'd7);                       // disabled slots
    send(CMD_REPORT, 0, 0, 0);
    set_cfg(8'h81);

    // Random: mostly time-ordered transfers between random stages
    masks = '{8'hFF, 8'h81, 8'h3C, 8'h01, 8'hA5};
    for (int ph = 0; ph < 5; ph++) begin
      set_cfg(ph == 4 ? 8'($urandom) : masks[ph]);
      for (int i = 0; i < 77; i++) begin
        idle_gap();
        if ($urandom_range(0, 19) == 0)
          send(CMD_REPORT, $urandom, $urandom, 63'({$urandom, $urandom}));
        else if ($urandom_range(0, 9) == 0) begin
          ts = 63'({$urandom, $urandom});
          send(CMD_XFER, $urandom, $urandom, ts);
        end else
          xfer($urandom_range(0, 7), $urandom_range(0, 7),
               ($urandom_range(0, 9) == 0) ? 32'h2000_0000 : 5000);
        if (i == 40) drain();
      end
      send(CMD_REPORT, 0, 0, 0);
    end

    drain();
    if (board.errors == 0 && board.pending.size() == 0)
      $display("stage_latency_welford_monitor regression: pass");
    else
      $display("stage_latency_welford_monitor regression: fail");
    $finish;
  end
endmodule

@@ files.f @@
src/slwm_pkg.sv
src/slwm_div.sv
src/stage_latency_welford_monitor.sv
dv/stage_latency_welford_monitor_test.sv
